/* hdl/mp2_pkg.sv */
// shared types, constants and the compare and clamp functions of the 2x2 max pooling block
package mp2_pkg;

   localparam int SAMPLE_BITS    = 16;
   localparam int MAX_WIDTH      = 1024;
   localparam int HEIGHT_LIMIT   = 1024;
   localparam int DIM_BITS       = 11;
   localparam int COL_BITS       = $clog2(MAX_WIDTH);
   localparam int ROW_BITS       = $clog2(HEIGHT_LIMIT);
   localparam int LINE_DEPTH     = MAX_WIDTH / 2;
   localparam int LINE_ADDR_BITS = $clog2(LINE_DEPTH);
   localparam int LINE_BITS      = SAMPLE_BITS + 1;
   localparam int CSR_INDEX_BITS = 2;
   localparam int QUEUE_DEPTH    = 2;
   localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_BITS    = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PLANE_WIDTH  = 2'd0,
      CSR_PLANE_HEIGHT = 2'd1
   } csr_index_type;

   // one candidate for the maximum with its place in the window
   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] value;
      logic                          row;
      logic                          col;
   } cand_type;

   typedef struct packed {
      logic clear;
      logic load;
      logic merge;
   } cell_ctl_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] pooled_value;
      logic                          max_row_offset;
      logic                          max_col_offset;
      logic                          last_of_plane;
   } rsp_word_type;

   // larger value wins, a tie goes to the earlier place in column-major order
   function automatic cand_type pick_max(cand_type a, cand_type b);
      logic a_wins;
      a_wins = (a.value > b.value) ||
               ((a.value == b.value) && ({a.col, a.row} < {b.col, b.row}));
      return a_wins ? a : b;
   endfunction

   function automatic logic [DIM_BITS-1:0] clamp_dim(logic [DIM_BITS-1:0] v,
                                                     logic [DIM_BITS-1:0] hi);
      logic [DIM_BITS-1:0] r;
      r = v;
      if (v < DIM_BITS'(2)) begin
         r = DIM_BITS'(2);
      end else if (v > hi) begin
         r = hi;
      end
      return r;
   endfunction

endpackage

/* hdl/mp2_if.sv */
// channel interfaces: sample input, pooled result output and register writes
interface mp2_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [mp2_pkg::SAMPLE_BITS-1:0] sample;
   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

interface mp2_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [mp2_pkg::SAMPLE_BITS-1:0] pooled_value;
   logic                                  max_row_offset;
   logic                                  max_col_offset;
   logic                                  last_of_plane;
   modport source (output valid, output pooled_value, output max_row_offset,
                   output max_col_offset, output last_of_plane, input ready);
   modport sink (input valid, input pooled_value, input max_row_offset,
                 input max_col_offset, input last_of_plane, output ready);
endinterface

interface mp2_csr_if;
   logic                               valid;
   logic                               ready;
   logic [mp2_pkg::CSR_INDEX_BITS-1:0] index;
   logic [mp2_pkg::DIM_BITS-1:0]       data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

/* hdl/mp2_ram.sv */
// generic single write port, single read port ram with registered read data
module mp2_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/mp2_cell.sv */
// compare cell: holds one candidate and merges it with the one at its input
module mp2_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  mp2_pkg::cell_ctl_type ctl,
   input  mp2_pkg::cand_type     in_cand,
   output mp2_pkg::cand_type     best
);

   mp2_pkg::cand_type held_ff;
   mp2_pkg::cand_type held_in;
   mp2_pkg::cand_type pick;

   assign pick = mp2_pkg::pick_max(held_ff, in_cand);

   always_comb begin
      held_in = held_ff;
      if (ctl.clear) begin
         held_in = '0;
      end else if (ctl.load) begin
         held_in = in_cand;
      end else if (ctl.merge) begin
         held_in = pick;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else begin
         held_ff <= held_in;
      end
   end

   assign best = pick;

endmodule

/* hdl/mp2_out_queue.sv */
// two-word result queue that decouples the pooling cells from the result channel
module mp2_out_queue (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   input  mp2_pkg::rsp_word_type             push_word,
   output logic [mp2_pkg::QCOUNT_BITS-1:0]   count,
   mp2_rsp_if.source                         rsp_chan
);

   mp2_pkg::rsp_word_type                slot_ff [mp2_pkg::QUEUE_DEPTH];
   logic [mp2_pkg::QPTR_BITS-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [mp2_pkg::QPTR_BITS-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [mp2_pkg::QCOUNT_BITS-1:0]      count_ff, count_in;
   logic                                 pop;
   mp2_pkg::rsp_word_type                head;

   assign pop  = rsp_chan.valid && rsp_chan.ready;
   assign head = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

   assign count                   = count_ff;
   assign rsp_chan.valid          = (count_ff != '0);
   assign rsp_chan.pooled_value   = head.pooled_value;
   assign rsp_chan.max_row_offset = head.max_row_offset;
   assign rsp_chan.max_col_offset = head.max_col_offset;
   assign rsp_chan.last_of_plane  = head.last_of_plane;

   // the input side holds back early enough that a word never meets a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != mp2_pkg::QCOUNT_BITS'(mp2_pkg::QUEUE_DEPTH)))
      else $error("result pushed into a full queue");

endmodule

/* hdl/max_pool_2x2_argmax_top.sv */
// 2x2 stride-2 max pooling with argmax over a raster-order sample stream
// The block takes one signed 16-bit sample per cycle, back to back, and gives one result
// for each complete 2x2 window: the maximum, its row and column inside the window (ties
// go to top-left, bottom-left, top-right, bottom-right in that order) and a flag on the
// last window of the plane. Input stalls only when the two-word result queue backs up.
// Two compare cells in a row do the work: the first keeps the better sample of each
// horizontal pair, the second meets the pair of an odd row with the pair stored for the
// row above in a 512 x 17-bit line buffer ram (one write or one read per cycle). The line
// buffer needs no clearing after reset. Writing plane width or plane height (clamped to
// 2..1024) restarts the plane; an odd last column or row is consumed without a result.
module max_pool_2x2_argmax_top (
   input logic       clock,
   input logic       reset,
   mp2_req_if.sink   req_chan,
   mp2_rsp_if.source rsp_chan,
   mp2_csr_if.sink   csr_chan
);

   logic [mp2_pkg::DIM_BITS-1:0]       width_ff, width_in;
   logic [mp2_pkg::DIM_BITS-1:0]       height_ff, height_in;
   logic [mp2_pkg::COL_BITS-1:0]       col_ff, col_in;
   logic [mp2_pkg::ROW_BITS-1:0]       row_ff, row_in;
   logic                               bot_valid_ff, bot_valid_in;
   logic                               last_ff, last_in;

   logic                               csr_fire;
   logic                               restart;
   logic                               req_fire;
   logic [mp2_pkg::DIM_BITS-1:0]       col_ext, row_ext;
   logic [mp2_pkg::DIM_BITS-1:0]       col_next, row_next;
   logic [mp2_pkg::DIM_BITS-1:0]       used_w, used_h;
   logic                               in_range;
   logic                               pair_done;
   logic                               last_hit;
   logic                               wr_en, rd_en;
   logic [mp2_pkg::LINE_BITS-1:0]      line_wr_data, line_rd_data;
   logic [mp2_pkg::LINE_ADDR_BITS-1:0] line_addr;
   logic [mp2_pkg::QCOUNT_BITS-1:0]    q_count;

   mp2_pkg::cell_ctl_type              pair_ctl, win_ctl;
   mp2_pkg::cand_type                  pair_in, pair_best, win_in, win_best;
   mp2_pkg::cand_type                  bot_cand, top_cand;
   mp2_pkg::rsp_word_type              push_word;

   // configuration
   assign csr_fire       = csr_chan.valid && csr_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign restart        = csr_fire &&
                           ((csr_chan.index == mp2_pkg::CSR_PLANE_WIDTH) ||
                            (csr_chan.index == mp2_pkg::CSR_PLANE_HEIGHT));

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_fire) begin
         case (csr_chan.index)
            mp2_pkg::CSR_PLANE_WIDTH: begin
               width_in = mp2_pkg::clamp_dim(csr_chan.data,
                                             mp2_pkg::DIM_BITS'(mp2_pkg::MAX_WIDTH));
            end
            mp2_pkg::CSR_PLANE_HEIGHT: begin
               height_in = mp2_pkg::clamp_dim(csr_chan.data,
                                              mp2_pkg::DIM_BITS'(mp2_pkg::HEIGHT_LIMIT));
            end
            default: begin
               width_in  = width_ff;
               height_in = height_ff;
            end
         endcase
      end
   end

   // room for this word's result once the words already in flight have landed
   assign req_chan.ready = (q_count == '0) ||
                           ((q_count == mp2_pkg::QCOUNT_BITS'(1)) && !bot_valid_ff);
   assign req_fire       = req_chan.valid && req_chan.ready;

   // raster position
   assign col_ext  = mp2_pkg::DIM_BITS'(col_ff);
   assign row_ext  = mp2_pkg::DIM_BITS'(row_ff);
   assign col_next = col_ext + 1'b1;
   assign row_next = row_ext + 1'b1;
   assign used_w   = {width_ff[mp2_pkg::DIM_BITS-1:1], 1'b0};
   assign used_h   = {height_ff[mp2_pkg::DIM_BITS-1:1], 1'b0};
   assign in_range = (col_ext < used_w) && (row_ext < used_h);
   assign last_hit = (col_ext == used_w - 1'b1) && (row_ext == used_h - 1'b1);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (req_fire) begin
         if (col_next >= width_ff) begin
            col_in = '0;
            row_in = (row_next >= height_ff) ? '0 : row_next[mp2_pkg::ROW_BITS-1:0];
         end else begin
            col_in = col_next[mp2_pkg::COL_BITS-1:0];
         end
      end
   end

   // horizontal pair cell
   assign pair_done      = req_fire && in_range && col_ff[0];
   assign pair_ctl.clear = restart;
   assign pair_ctl.load  = req_fire && in_range && !col_ff[0];
   assign pair_ctl.merge = pair_done;
   assign pair_in.value  = req_chan.sample;
   assign pair_in.row    = 1'b0;
   assign pair_in.col    = col_ff[0];

   mp2_cell u_pair_cell (
      .clock   (clock),
      .reset   (reset),
      .ctl     (pair_ctl),
      .in_cand (pair_in),
      .best    (pair_best)
   );

   // line buffer: even rows store the pair winner, odd rows fetch it back
   assign wr_en        = pair_done && !row_ff[0];
   assign rd_en        = pair_done && row_ff[0];
   assign line_addr    = col_ff[mp2_pkg::COL_BITS-1:1];
   assign line_wr_data = {pair_best.value, pair_best.col};

   mp2_ram #(
      .WIDTH (mp2_pkg::LINE_BITS),
      .DEPTH (mp2_pkg::LINE_DEPTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (line_addr),
      .wr_data (line_wr_data),
      .rd_en   (rd_en),
      .rd_addr (line_addr),
      .rd_data (line_rd_data)
   );

   // window cell: loads the bottom pair, next cycle meets the top pair from the ram
   assign bot_cand.value = pair_best.value;
   assign bot_cand.row   = 1'b1;
   assign bot_cand.col   = pair_best.col;
   assign top_cand.value = line_rd_data[mp2_pkg::LINE_BITS-1:1];
   assign top_cand.row   = 1'b0;
   assign top_cand.col   = line_rd_data[0];
   assign win_in         = rd_en ? bot_cand : top_cand;
   assign win_ctl.clear  = restart;
   assign win_ctl.load   = rd_en;
   assign win_ctl.merge  = 1'b0;

   mp2_cell u_win_cell (
      .clock   (clock),
      .reset   (reset),
      .ctl     (win_ctl),
      .in_cand (win_in),
      .best    (win_best)
   );

   assign bot_valid_in = rd_en;
   assign last_in      = rd_en ? last_hit : last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= mp2_pkg::DIM_BITS'(mp2_pkg::MAX_WIDTH);
         height_ff    <= mp2_pkg::DIM_BITS'(mp2_pkg::HEIGHT_LIMIT);
         col_ff       <= '0;
         row_ff       <= '0;
         bot_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         bot_valid_ff <= bot_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff <= last_in;
   end

   assign push_word.pooled_value   = win_best.value;
   assign push_word.max_row_offset = win_best.row;
   assign push_word.max_col_offset = win_best.col;
   assign push_word.last_of_plane  = last_ff;

   mp2_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (bot_valid_ff),
      .push_word (push_word),
      .count     (q_count),
      .rsp_chan  (rsp_chan)
   );

   a_bot_from_accept: assert property (@(posedge clock) disable iff (reset)
      bot_valid_ff |-> $past(req_fire && row_ff[0] && col_ff[0]))
      else $error("window stage valid without a closing word");

   a_no_back_to_back_windows: assert property (@(posedge clock) disable iff (reset)
      bot_valid_ff |=> !bot_valid_ff)
      else $error("two windows closed on consecutive cycles");

   a_ram_one_access: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en))
      else $error("line buffer read and written in the same cycle");

   a_last_only_on_final_window: assert property (@(posedge clock) disable iff (reset)
      (bot_valid_ff && last_ff) |-> $past(last_hit))
      else $error("last of plane flagged on a window that does not close the plane");

endmodule

/* tb/sv/testbench.sv */
// self-checking testbench of the 2x2 max pooling block with argmax
`timescale 1ns / 1ps

module testbench;

   localparam logic [mp2_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE_INDEX = 2'd3;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_SAMPLES = 1750;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int LONG_TAIL_SAMPLES = 256;

   typedef enum int {STYLE_WIDE, STYLE_TIES, STYLE_EDGES} sample_style_type;
   typedef enum int {RX_OPEN, RX_HALF, RX_SPARSE, RX_PULSE} rx_mode_type;

   // best sample of a horizontal pair and the column it came from
   typedef struct packed {
      logic signed [mp2_pkg::SAMPLE_BITS-1:0] value;
      logic                                   col;
   } pair_pick_type;

   // directed windows: tie and extreme cases, two columns per window
   localparam logic [mp2_pkg::SAMPLE_BITS-1:0] WIN_TOP [16] = '{
      16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'hffff, 16'h7fff, 16'h0000, 16'h0000,
      16'h0000, 16'h0000, 16'h0000, 16'h0007, 16'h0000, 16'h0007, 16'h0003, 16'hfffb};
   localparam logic [mp2_pkg::SAMPLE_BITS-1:0] WIN_BOTTOM [16] = '{
      16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h0000, 16'h0005, 16'h0000,
      16'h0000, 16'h0005, 16'h0007, 16'h0000, 16'h0000, 16'h0007, 16'h0003, 16'h0003};

   logic clock = 1'b0;
   logic reset = 1'b1;

   mp2_req_if req_bus();
   mp2_rsp_if rsp_bus();
   mp2_csr_if csr_bus();

   max_pool_2x2_argmax_top u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // samples waiting to be offered, pooled words waiting to come out
   logic [mp2_pkg::SAMPLE_BITS-1:0] pending_q[$];
   mp2_pkg::rsp_word_type           pooled_q[$];

   // predictor state
   logic [mp2_pkg::DIM_BITS-1:0] cfg_width = mp2_pkg::DIM_BITS'(mp2_pkg::MAX_WIDTH);
   logic [mp2_pkg::DIM_BITS-1:0] cfg_height = mp2_pkg::DIM_BITS'(mp2_pkg::HEIGHT_LIMIT);
   int                           cur_row = 0;
   int                           cur_col = 0;
   pair_pick_type                pair_hold = '0;
   pair_pick_type                upper_pairs [mp2_pkg::LINE_DEPTH];

   int error_count = 0;
   int samples_taken = 0;
   int pooled_checked = 0;
   int planes_closed = 0;
   int csr_writes = 0;

   logic        sample_taken = 1'b0;
   int          burst_left = 1;
   int          gap_left = 0;
   int          hold_left = 0;
   logic        hold_request = 1'b0;
   int          rx_mode_left = 1;
   rx_mode_type rx_mode = RX_OPEN;
   logic [7:0]  rx_pattern = 8'b1011_0010;
   logic        rx_ready;
   mp2_pkg::rsp_word_type want;

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= 50) begin
         $display("mismatch at %0t: %s", $time, what);
      end
   endtask

   task automatic restart_plane();
      cur_row = 0;
      cur_col = 0;
      pair_hold = '0;
   endtask

   task automatic add_sample(input logic [mp2_pkg::SAMPLE_BITS-1:0] v);
      pending_q = {pending_q, v};
   endtask

   // one accepted sample through the pooling predictor
   task automatic pool_sample(input logic signed [mp2_pkg::SAMPLE_BITS-1:0] s);
      int w, h, used_w, used_h, idx;
      logic signed [mp2_pkg::SAMPLE_BITS-1:0] top_val, bot_val;
      pair_pick_type top, bot, win;
      logic take_bot;
      mp2_pkg::rsp_word_type word;
      w = (cfg_width < 2) ? 2 : (cfg_width > mp2_pkg::MAX_WIDTH) ? mp2_pkg::MAX_WIDTH
                                                                  : int'(cfg_width);
      h = (cfg_height < 2) ? 2 : (cfg_height > mp2_pkg::HEIGHT_LIMIT) ? mp2_pkg::HEIGHT_LIMIT
                                                                       : int'(cfg_height);
      used_w = w & ~1;
      used_h = h & ~1;
      if (cur_col < used_w && cur_row < used_h) begin
         if (cur_col % 2 == 0) begin
            pair_hold.value = s;
            pair_hold.col = 1'b0;
         end else begin
            idx = cur_col / 2;
            top_val = pair_hold.value;
            if (s > top_val) begin
               pair_hold.value = s;
               pair_hold.col = 1'b1;
            end
            if (cur_row % 2 == 0) begin
               upper_pairs[idx] = pair_hold;
            end else begin
               top = upper_pairs[idx];
               bot = pair_hold;
               top_val = top.value;
               bot_val = bot.value;
               if (bot_val != top_val) begin
                  take_bot = bot_val > top_val;
               end else begin
                  take_bot = bot.col < top.col;
               end
               win = take_bot ? bot : top;
               word.pooled_value = win.value;
               word.max_row_offset = take_bot;
               word.max_col_offset = win.col;
               word.last_of_plane = (cur_row == used_h - 1) && (cur_col == used_w - 1);
               pooled_q = {pooled_q, word};
            end
         end
      end
      cur_col++;
      if (cur_col >= w) begin
         cur_col = 0;
         cur_row++;
         if (cur_row >= h) begin
            cur_row = 0;
         end
      end
   endtask

   task automatic write_csr(input logic [mp2_pkg::CSR_INDEX_BITS-1:0] index,
                            input logic [mp2_pkg::DIM_BITS-1:0] data);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= data;
      do begin
         @(posedge clock);
      end while (!(csr_bus.valid && csr_bus.ready));
      csr_writes++;
      if (index == mp2_pkg::CSR_PLANE_WIDTH) begin
         cfg_width = data;
         restart_plane();
      end else if (index == mp2_pkg::CSR_PLANE_HEIGHT) begin
         cfg_height = data;
         restart_plane();
      end
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // all samples taken, all words out, then a settling wait for samples with no result
   task automatic wait_idle();
      do begin
         @(posedge clock);
      end while (pending_q.size() != 0 || req_bus.valid || pooled_q.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [mp2_pkg::SAMPLE_BITS-1:0] make_sample(
      input sample_style_type style);
      logic [mp2_pkg::SAMPLE_BITS-1:0] v;
      case (style)
         STYLE_TIES: begin
            v = mp2_pkg::SAMPLE_BITS'($urandom_range(0, 3)) - mp2_pkg::SAMPLE_BITS'(2);
         end
         STYLE_EDGES: begin
            case ($urandom_range(0, 5))
               0: v = 16'h8000;
               1: v = 16'h7fff;
               2: v = 16'hffff;
               3: v = 16'h0000;
               4: v = 16'h0001;
               default: v = 16'h8001;
            endcase
         end
         default: begin
            v = mp2_pkg::SAMPLE_BITS'($urandom);
         end
      endcase
      return v;
   endfunction

   task automatic queue_samples(input int n, input sample_style_type style);
      for (int i = 0; i < n; i++) begin
         add_sample(make_sample(style));
      end
   endtask

   // sample driver: bursts with gaps, holds a word until it is taken
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!(req_bus.valid && !sample_taken)) begin
         if (gap_left > 0) begin
            gap_left--;
            req_bus.valid <= 1'b0;
         end else if (pending_q.size() != 0) begin
            req_bus.valid  <= 1'b1;
            req_bus.sample <= pending_q[0];
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                        : $urandom_range(1, 30);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
      sample_taken = 1'b0;
   end

   // result receiver: changing stall pattern, plus one long hold-off on request
   always @(negedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rx_ready = 1'b0;
      end else begin
         rx_mode_left--;
         if (rx_mode_left <= 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(16, 200);
         end
         rx_pattern = {rx_pattern[0], rx_pattern[7:1]};
         case (rx_mode)
            RX_HALF:   rx_ready = $urandom_range(0, 1);
            RX_SPARSE: rx_ready = ($urandom_range(0, 3) == 0);
            RX_PULSE:  rx_ready = rx_pattern[0];
            default:   rx_ready = 1'b1;
         endcase
      end
      rsp_bus.ready <= rx_ready;
   end

   // monitor: predict on every taken sample, check every pooled word
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            void'(pending_q.pop_front());
            pool_sample(req_bus.sample);
            samples_taken++;
            sample_taken = 1'b1;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pooled_q.size() == 0) begin
               report_mismatch($sformatf("word with nothing expected, value %0d",
                                         rsp_bus.pooled_value));
            end else begin
               want = pooled_q.pop_front();
               pooled_checked++;
               if (rsp_bus.pooled_value !== want.pooled_value) begin
                  report_mismatch($sformatf("pooled_value %0d, expected %0d",
                                            rsp_bus.pooled_value, want.pooled_value));
               end
               if (rsp_bus.max_row_offset !== want.max_row_offset) begin
                  report_mismatch($sformatf("max_row_offset %b, expected %b",
                                            rsp_bus.max_row_offset, want.max_row_offset));
               end
               if (rsp_bus.max_col_offset !== want.max_col_offset) begin
                  report_mismatch($sformatf("max_col_offset %b, expected %b",
                                            rsp_bus.max_col_offset, want.max_col_offset));
               end
               if (rsp_bus.last_of_plane !== want.last_of_plane) begin
                  report_mismatch($sformatf("last_of_plane %b, expected %b",
                                            rsp_bus.last_of_plane, want.last_of_plane));
               end
               if (want.last_of_plane) begin
                  planes_closed++;
               end
            end
         end
      end
   end

   initial begin
      #20_000_000;
      $display("tb: failure");
      $finish;
   end

   initial begin : stimulus
      int random_items;
      int phase;
      int w_eff, h_eff, plane, n;
      int unsigned sel;
      logic [mp2_pkg::DIM_BITS-1:0] w_pick, h_pick;
      sample_style_type style;

      req_bus.valid = 1'b0;
      req_bus.sample = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = mp2_pkg::CSR_PLANE_WIDTH;
      csr_bus.data = '0;
      restart_plane();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // eight windows over two 8x2 planes: extremes and ties within a row
      write_csr(mp2_pkg::CSR_PLANE_WIDTH, 11'd8);
      write_csr(mp2_pkg::CSR_PLANE_HEIGHT, 11'd2);
      for (int i = 0; i < 16; i++) begin
         add_sample(WIN_TOP[i]);
      end
      for (int i = 0; i < 16; i++) begin
         add_sample(WIN_BOTTOM[i]);
      end
      wait_idle();

      // odd width and height: last column and row give nothing
      write_csr(mp2_pkg::CSR_PLANE_WIDTH, 11'd3);
      write_csr(mp2_pkg::CSR_PLANE_HEIGHT, 11'd3);
      queue_samples(9, STYLE_WIDE);
      wait_idle();

      random_items = 0;
      phase = 0;
      while (random_items < RANDOM_SAMPLES) begin
         if (phase == 1) begin
            // widest plane with the smallest height, receiver holds off in the odd row
            write_csr(mp2_pkg::CSR_PLANE_WIDTH, 11'd2047);
            write_csr(mp2_pkg::CSR_PLANE_HEIGHT, 11'd1);
            queue_samples(mp2_pkg::MAX_WIDTH + LONG_TAIL_SAMPLES, STYLE_WIDE);
            random_items += mp2_pkg::MAX_WIDTH + LONG_TAIL_SAMPLES;
            while (pending_q.size() > LONG_TAIL_SAMPLES) begin
               @(posedge clock);
            end
            hold_request = 1'b1;
            wait_idle();
         end else if (phase == 0) begin
            // narrowest width, tallest height, only the first rows
            write_csr(mp2_pkg::CSR_PLANE_WIDTH, 11'd0);
            write_csr(mp2_pkg::CSR_PLANE_HEIGHT, 11'd2047);
            queue_samples(60, STYLE_TIES);
            random_items += 60;
            wait_idle();
         end
         case ($urandom_range(0, 9))
            0: w_pick = mp2_pkg::DIM_BITS'($urandom_range(0, 3));
            1: w_pick = mp2_pkg::DIM_BITS'($urandom_range(25, 80));
            default: w_pick = mp2_pkg::DIM_BITS'($urandom_range(2, 16));
         endcase
         case ($urandom_range(0, 9))
            0: h_pick = ($urandom_range(0, 2) == 0) ? 11'd3
                                                    : mp2_pkg::DIM_BITS'($urandom_range(0, 1));
            1: h_pick = ($urandom_range(0, 1) == 0) ? 11'd2047 : 11'd1023;
            default: h_pick = mp2_pkg::DIM_BITS'($urandom_range(2, 8));
         endcase
         sel = $urandom_range(0, 9);
         if (sel == 0) begin
            write_csr(mp2_pkg::CSR_PLANE_WIDTH, w_pick);
         end else if (sel == 1) begin
            write_csr(mp2_pkg::CSR_PLANE_HEIGHT, h_pick);
         end else if (sel == 2) begin
            // unused index: the plane just carries on
            write_csr(CSR_SPARE_INDEX, mp2_pkg::DIM_BITS'($urandom));
         end else begin
            write_csr(mp2_pkg::CSR_PLANE_WIDTH, w_pick);
            write_csr(mp2_pkg::CSR_PLANE_HEIGHT, h_pick);
         end
         w_eff = (cfg_width < 2) ? 2 : (cfg_width > mp2_pkg::MAX_WIDTH) ? mp2_pkg::MAX_WIDTH
                                                                         : int'(cfg_width);
         h_eff = (cfg_height < 2) ? 2 : (cfg_height > mp2_pkg::HEIGHT_LIMIT)
                                        ? mp2_pkg::HEIGHT_LIMIT : int'(cfg_height);
         plane = w_eff * h_eff;
         if (plane > 300) begin
            n = $urandom_range(50, 300);
         end else begin
            sel = $urandom_range(0, 9);
            if (sel < 6) begin
               n = plane * $urandom_range(1, 3);
            end else begin
               n = $urandom_range(1, 2 * plane);
            end
         end
         style = sample_style_type'($urandom_range(0, 2));
         queue_samples(n, style);
         random_items += n;
         wait_idle();
         phase++;
      end

      wait_idle();
      if (pooled_q.size() != 0) begin
         report_mismatch($sformatf("%0d pooled words never came out", pooled_q.size()));
      end
      $display("summary: %0d samples through %0d register writes, %0d pooled words checked",
               samples_taken, csr_writes, pooled_checked);
      $display("summary: %0d planes closed, %0d mismatches", planes_closed, error_count);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

/* files.f */
hdl/mp2_pkg.sv
hdl/mp2_if.sv
hdl/mp2_ram.sv
hdl/mp2_cell.sv
hdl/mp2_out_queue.sv
hdl/max_pool_2x2_argmax_top.sv
tb/sv/testbench.sv
